/* hw/rtl/bba_pkg.sv */
// Buddy allocator package: sizes, codes, entry and request/response types.
// Shared by the sequencer and the top level; no dependencies.
package bba_pkg;

  localparam int LEVELS          = 12;
  localparam int MIN_BLOCK_BYTES = 16;
  localparam int NUM_PAGES       = 32;
  localparam int TOP_LEVEL       = LEVELS - 1;
  localparam int PAGE_SHIFT      = TOP_LEVEL;
  localparam int ADDR_W          = 16;
  localparam int LINK_W          = 17;
  localparam int LVL_W           = $clog2(LEVELS);
  localparam int PG_W            = $clog2(NUM_PAGES);
  localparam int SIZE_W          = 24;
  localparam int BYTES_W         = 21;
  localparam int PAGES_W         = 6;
  localparam int TOTAL_UNITS     = NUM_PAGES * (2 ** TOP_LEVEL);

  // Null link: one past the last unit of the region.
  localparam logic [LINK_W-1:0] NIL = LINK_W'(TOTAL_UNITS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  // One entry per minimum-block unit.
  typedef struct packed {
    logic              mark;
    logic [LVL_W-1:0]  tag;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
  } ent_t;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    status_t            status;
    logic [BYTES_W-1:0] bytes;
    logic [PAGES_W-1:0] pages;
  } rsp_t;

  function automatic logic is_link(input logic [LINK_W-1:0] lnk);
    return lnk < NIL;
  endfunction

  // Smallest level whose block holds the size, saturating at the top level.
  function automatic logic [LVL_W-1:0] level_of(input logic [SIZE_W-1:0] size);
    int cnt;
    cnt = 0;
    for (int l = 0; l < TOP_LEVEL; l++) begin
      if ((64'(MIN_BLOCK_BYTES) << l) < 64'(size)) cnt++;
    end
    return LVL_W'(cnt);
  endfunction

  function automatic logic [BYTES_W-1:0] bytes_of(input logic [LVL_W-1:0] lvl);
    return BYTES_W'(MIN_BLOCK_BYTES) << lvl;
  endfunction

endpackage

/* hw/rtl/bba_ram.sv */
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No package dependency.
module bba_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 39
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/bba_seq.sv */
// Allocate/free sequencer: free-list heads, page map, counters and the
// read-modify-write steps on the entry RAM. Depends on bba_pkg.
module bba_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  bba_pkg::req_t                 req,
  output logic                          ready,
  output logic                          done,
  input  logic                          ack,
  output bba_pkg::rsp_t                 rsp,
  output logic                          ram_we,
  output logic [bba_pkg::ADDR_W-1:0]    ram_waddr,
  output bba_pkg::ent_t                 ram_wdata,
  output logic [bba_pkg::ADDR_W-1:0]    ram_raddr,
  input  bba_pkg::ent_t                 ram_rdata
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DEC, S_RMW_RD, S_RMW_WR, S_UL_RD, S_UL_CAP, S_UL_X,
    S_PUSH, S_PUSH_W, S_A_CLR, S_A_SPLIT, S_F_BUD, S_F_CHK, S_F_M1, S_F_M2,
    S_F_END, S_F_SUB, S_DONE
  } state_t;

  typedef enum logic [1:0] {K_MARK, K_NEXT, K_PREV, K_NEWPG} kind_t;

  state_t                          state_r, rmw_ret_r, ul_ret_r, push_ret_r;
  kind_t                           rmw_kind_r;
  logic [bba_pkg::LINK_W-1:0]      clr_r;
  bba_pkg::req_t                   req_r;
  logic [bba_pkg::LVL_W-1:0]       level_r, k_r, lv_r, push_lv_r;
  logic [bba_pkg::ADDR_W-1:0]      res_r, fh_r, bud_r, rmw_addr_r, ul_n_r, push_n_r;
  logic [bba_pkg::LINK_W-1:0]      rmw_val_r, ul_p_r, ul_x_r;
  logic                            newpg_r;
  logic [bba_pkg::LINK_W-1:0]      head_r [bba_pkg::LEVELS];
  logic [bba_pkg::NUM_PAGES-1:0]   page_used_r;
  logic [bba_pkg::BYTES_W-1:0]     alloc_tot_r;
  logic [bba_pkg::PAGES_W-1:0]     page_tot_r;
  bba_pkg::status_t                status_r;
  logic [bba_pkg::ADDR_W-1:0]      result_r;

  logic                            hit_found, pg_found;
  logic [bba_pkg::LVL_W-1:0]       hit_k;
  logic [bba_pkg::PG_W-1:0]        pg_idx;
  logic [bba_pkg::ADDR_W-1:0]      bud;
  bba_pkg::ent_t                   mod_ent;

  // Lowest non-empty list at or above the request level, lowest free page.
  always_comb begin
    hit_found = 1'b0;
    hit_k     = '0;
    for (int k = bba_pkg::LEVELS - 1; k >= 0; k--) begin
      if (bba_pkg::LVL_W'(k) >= level_r && bba_pkg::is_link(head_r[k])) begin
        hit_found = 1'b1;
        hit_k     = bba_pkg::LVL_W'(k);
      end
    end
    pg_found = 1'b0;
    pg_idx   = '0;
    for (int p = bba_pkg::NUM_PAGES - 1; p >= 0; p--) begin
      if (!page_used_r[p]) begin
        pg_found = 1'b1;
        pg_idx   = bba_pkg::PG_W'(p);
      end
    end
  end

  assign bud = fh_r ^ (bba_pkg::ADDR_W'(1) << lv_r);

  always_comb begin
    mod_ent = ram_rdata;
    case (rmw_kind_r)
      K_MARK:  mod_ent.mark = rmw_val_r[0];
      K_NEXT:  mod_ent.nxt  = rmw_val_r;
      K_PREV:  mod_ent.prv  = rmw_val_r;
      K_NEWPG: begin
        mod_ent.mark = 1'b0;
        mod_ent.tag  = bba_pkg::LVL_W'(bba_pkg::TOP_LEVEL);
      end
      default: mod_ent = ram_rdata;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r[bba_pkg::ADDR_W-1:0];
      end
      S_RMW_RD: ram_raddr = rmw_addr_r;
      S_RMW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = rmw_addr_r;
        ram_wdata = mod_ent;
      end
      S_UL_RD: ram_raddr = ul_n_r;
      S_PUSH_W: begin
        ram_we         = 1'b1;
        ram_waddr      = push_n_r;
        ram_wdata.mark = 1'b1;
        ram_wdata.tag  = push_lv_r;
        ram_wdata.nxt  = head_r[push_lv_r];
        ram_wdata.prv  = bba_pkg::NIL;
      end
      S_F_BUD: ram_raddr = bud;
      default: ram_raddr = '0;
    endcase
  end

  assign ready = (state_r == S_IDLE);
  assign done  = (state_r == S_DONE);
  assign rsp   = '{addr: result_r, status: status_r, bytes: alloc_tot_r,
                   pages: page_tot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      page_used_r <= '0;
      alloc_tot_r <= '0;
      page_tot_r  <= '0;
      for (int i = 0; i < bba_pkg::LEVELS; i++) head_r[i] <= bba_pkg::NIL;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == bba_pkg::NIL - 1'b1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_r   <= req;
            level_r <= bba_pkg::level_of(req.size);
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          result_r <= '0;
          if (level_r >= bba_pkg::LVL_W'(bba_pkg::TOP_LEVEL)) begin
            status_r <= bba_pkg::ST_TOO_LARGE;
            state_r  <= S_DONE;
          end else if (req_r.op == bba_pkg::OP_ALLOC) begin
            if (hit_found) begin
              status_r <= bba_pkg::ST_OK;
              newpg_r  <= 1'b0;
              res_r    <= head_r[hit_k][bba_pkg::ADDR_W-1:0];
              k_r      <= hit_k;
              ul_n_r   <= head_r[hit_k][bba_pkg::ADDR_W-1:0];
              ul_ret_r <= S_A_CLR;
              state_r  <= S_UL_RD;
            end else if (pg_found) begin
              status_r   <= bba_pkg::ST_OK;
              page_used_r[pg_idx] <= 1'b1;
              page_tot_r <= page_tot_r + 1'b1;
              res_r      <= bba_pkg::ADDR_W'(pg_idx) << bba_pkg::PAGE_SHIFT;
              k_r        <= bba_pkg::LVL_W'(bba_pkg::TOP_LEVEL);
              newpg_r    <= 1'b1;
              state_r    <= S_A_CLR;
            end else begin
              status_r <= bba_pkg::ST_NO_MEM;
              state_r  <= S_DONE;
            end
          end else if (bba_pkg::is_link({1'b0, req_r.addr})) begin
            status_r   <= bba_pkg::ST_OK;
            fh_r       <= req_r.addr;
            lv_r       <= level_r;
            rmw_addr_r <= req_r.addr;
            rmw_kind_r <= K_MARK;
            rmw_val_r  <= bba_pkg::LINK_W'(1);
            rmw_ret_r  <= S_F_BUD;
            state_r    <= S_RMW_RD;
          end else begin
            status_r <= bba_pkg::ST_OK;
            state_r  <= S_DONE;
          end
        end
        S_RMW_RD: state_r <= S_RMW_WR;
        S_RMW_WR: state_r <= rmw_ret_r;
        S_UL_RD:  state_r <= S_UL_CAP;
        S_UL_CAP: begin
          ul_p_r <= ram_rdata.prv;
          ul_x_r <= ram_rdata.nxt;
          if (!bba_pkg::is_link(ram_rdata.prv)) begin
            if (ram_rdata.tag < bba_pkg::LVL_W'(bba_pkg::LEVELS)) begin
              head_r[ram_rdata.tag] <= ram_rdata.nxt;
            end
            state_r <= S_UL_X;
          end else begin
            rmw_addr_r <= ram_rdata.prv[bba_pkg::ADDR_W-1:0];
            rmw_kind_r <= K_NEXT;
            rmw_val_r  <= ram_rdata.nxt;
            rmw_ret_r  <= S_UL_X;
            state_r    <= S_RMW_RD;
          end
        end
        S_UL_X: begin
          if (bba_pkg::is_link(ul_x_r)) begin
            rmw_addr_r <= ul_x_r[bba_pkg::ADDR_W-1:0];
            rmw_kind_r <= K_PREV;
            rmw_val_r  <= ul_p_r;
            rmw_ret_r  <= ul_ret_r;
            state_r    <= S_RMW_RD;
          end else begin
            state_r <= ul_ret_r;
          end
        end
        S_PUSH: begin
          if (bba_pkg::is_link(head_r[push_lv_r])) begin
            rmw_addr_r <= head_r[push_lv_r][bba_pkg::ADDR_W-1:0];
            rmw_kind_r <= K_PREV;
            rmw_val_r  <= {1'b0, push_n_r};
            rmw_ret_r  <= S_PUSH_W;
            state_r    <= S_RMW_RD;
          end else begin
            state_r <= S_PUSH_W;
          end
        end
        S_PUSH_W: begin
          head_r[push_lv_r] <= {1'b0, push_n_r};
          state_r           <= push_ret_r;
        end
        S_A_CLR: begin
          rmw_addr_r <= res_r;
          rmw_kind_r <= newpg_r ? K_NEWPG : K_MARK;
          rmw_val_r  <= '0;
          rmw_ret_r  <= S_A_SPLIT;
          state_r    <= S_RMW_RD;
        end
        S_A_SPLIT: begin
          if (k_r > level_r) begin
            push_n_r   <= res_r + (bba_pkg::ADDR_W'(1) << (k_r - 1'b1));
            push_lv_r  <= k_r - 1'b1;
            k_r        <= k_r - 1'b1;
            push_ret_r <= S_A_SPLIT;
            state_r    <= S_PUSH;
          end else begin
            alloc_tot_r <= alloc_tot_r + bba_pkg::bytes_of(level_r);
            result_r    <= res_r;
            state_r     <= S_DONE;
          end
        end
        S_F_BUD: begin
          if (lv_r < bba_pkg::LVL_W'(bba_pkg::TOP_LEVEL)) begin
            bud_r   <= bud;
            state_r <= S_F_CHK;
          end else begin
            state_r <= S_F_END;
          end
        end
        S_F_CHK: begin
          if (bba_pkg::is_link({1'b0, bud_r}) && ram_rdata.mark && ram_rdata.tag == lv_r) begin
            ul_n_r   <= bud_r;
            ul_ret_r <= S_F_M1;
            state_r  <= S_UL_RD;
          end else begin
            state_r <= S_F_END;
          end
        end
        S_F_M1: begin
          rmw_kind_r <= K_MARK;
          rmw_val_r  <= '0;
          rmw_ret_r  <= S_F_M2;
          state_r    <= S_RMW_RD;
          if (bud_r < fh_r) begin
            rmw_addr_r <= fh_r;
            fh_r       <= bud_r;
          end else begin
            rmw_addr_r <= bud_r;
          end
        end
        S_F_M2: begin
          rmw_addr_r <= fh_r;
          rmw_kind_r <= K_MARK;
          rmw_val_r  <= bba_pkg::LINK_W'(1);
          rmw_ret_r  <= S_F_BUD;
          lv_r       <= lv_r + 1'b1;
          state_r    <= S_RMW_RD;
        end
        S_F_END: begin
          if (lv_r == bba_pkg::LVL_W'(bba_pkg::TOP_LEVEL)) begin
            page_used_r[fh_r[bba_pkg::ADDR_W-1:bba_pkg::PAGE_SHIFT]] <= 1'b0;
            page_tot_r <= page_tot_r - 1'b1;
            rmw_addr_r <= fh_r;
            rmw_kind_r <= K_MARK;
            rmw_val_r  <= '0;
            rmw_ret_r  <= S_F_SUB;
            state_r    <= S_RMW_RD;
          end else begin
            push_n_r   <= fh_r;
            push_lv_r  <= lv_r;
            push_ret_r <= S_F_SUB;
            state_r    <= S_PUSH;
          end
        end
        S_F_SUB: begin
          alloc_tot_r <= alloc_tot_r - bba_pkg::bytes_of(level_r);
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (ack) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/buddy_block_allocator.sv */
// Buddy block allocator top level: stream ports, result register, sequencer
// and entry RAM. Depends on bba_pkg, bba_seq and bba_ram.
//
//  channel  | direction | tdata (low bit up)                  | tuser
//  ---------+-----------+-------------------------------------+-----------------
//  in_      | request   | size_bytes[23:0], block_address     | operation
//  out_     | result    | result_address, bytes_allocated,    | status
//           |           | pages_in_use, zero pad to 48 bits   |
//
// One request at a time. A too-large size or a free beyond the region goes
// from decode straight to the result. An allocate takes a block from a list,
// or a new page, and splits it down to the request level, pushing each upper
// half onto its list; a free merges with its free buddy level by level, then
// lists the block or releases a whole page. The time each takes is set by
// the read-modify-write steps on the one-read-port entry RAM.
// After reset a clearing pass writes all 65536 RAM entries, one per cycle,
// and in_tready stays low until it ends.
// A finished result sits in the output register while the next request is
// taken; the sequencer holds its result only when that register is full.
module buddy_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // size_bytes[23:0], block_address[39:24]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_address[15:0], bytes_allocated[36:16],
                                  // pages_in_use[42:37], zero[47:43]
  output logic [1:0]  out_tuser   // status
);

  bba_pkg::req_t                req;
  bba_pkg::rsp_t                seq_rsp, out_rsp_r;
  bba_pkg::ent_t                ram_wdata, ram_rdata;
  logic [bba_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic                         ram_we;
  logic                         seq_ready, seq_done, seq_ack, start;
  logic                         out_valid_r, out_valid_nxt;

  assign req = '{op: in_tuser, size: in_tdata[23:0], addr: in_tdata[39:24]};

  assign in_tready = seq_ready;
  assign start     = in_tvalid && in_tready;

  // Move a finished result into the output register when it is free or drains.
  assign seq_ack = seq_done && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_ack) out_rsp_r <= seq_rsp;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_rsp_r.pages, out_rsp_r.bytes, out_rsp_r.addr};
  assign out_tuser  = out_rsp_r.status;

  bba_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .ready     (seq_ready),
    .done      (seq_done),
    .ack       (seq_ack),
    .rsp       (seq_rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bba_ram #(
    .ADDR_BITS (bba_pkg::ADDR_W),
    .DATA_BITS ($bits(bba_pkg::ent_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A taken request keeps the input closed on the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_tready) else $error("input open right after a request");

  // A held result stays offered until the output register takes it.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done && !seq_ack |=> seq_done) else $error("result dropped by sequencer");

  // Failed requests report a zero address.
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bba_pkg::ST_NO_MEM || out_tuser == bba_pkg::ST_TOO_LARGE)
    |-> out_tdata[15:0] == 16'd0) else $error("nonzero address on failure");

endmodule
